### rtl/assert_macros.svh
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("%m: check failed");

`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(lbl, prop)

`define ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

### rtl/ahap_pkg.sv
package ahap_pkg;

	// field widths
	localparam int ALT_W      = 8;
	localparam int ACC_IN_W   = 9;
	localparam int LVL_W      = 8;
	localparam int TGT_W      = 10;
	localparam int GAIN_W     = 8;
	localparam int SCALE_W    = 5;
	localparam int KS_W       = 7;
	localparam int WING_W     = 9;
	localparam int DEV_W      = 8;
	localparam int ERR_W      = 12;
	localparam int RATE_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int TDATA_W    = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PGAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VGAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IGAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MRESET = 3'd6;

	typedef enum logic [1:0] {
		MODE_STD,
		MODE_CUSTOM,
		MODE_ALT,
		MODE_MANUAL
	} mode_t;

	// fixed gain sets
	localparam logic [GAIN_W-1:0] GAIN_P_STD = 8'h66;
	localparam logic [GAIN_W-1:0] GAIN_V_STD = 8'h4c;
	localparam logic [GAIN_W-1:0] GAIN_I_STD = 8'h33;
	localparam logic [KS_W-1:0]   GAIN_S_STD = 7'h50;
	localparam logic [GAIN_W-1:0] GAIN_M_STD = 8'h66;
	localparam logic [GAIN_W-1:0] GAIN_P_ALT = 8'h33;

	localparam logic [LVL_W-1:0] LOCK_LEVEL = 8'd127;
	localparam int DEV_MAX  = 127;
	localparam int DEV_MIN  = -128;
	localparam int WING_MAX = 255;
	localparam int WING_MIN = -255;
	localparam int INTEG_SHIFT = 8;

	// order of the gain terms fed through the multiplier
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_V = 2'd1;
	localparam logic [1:0] TERM_I = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WSUM,
		ST_WDRAIN,
		ST_TERMS,
		ST_TDRAIN,
		ST_SHIFT,
		ST_LIMIT,
		ST_OUT
	} state_t;

endpackage

### rtl/altitude_hold_autopilot_core.sv
// channel  | dir | handshake                     | payload
// s_       | in  | s_tvalid / s_tready           | s_tdata: altitude, accel, valid level
// m_       | out | m_tvalid / m_tready           | m_tdata: wing, locked, deviation, avg
//          |     |                               | m_tuser: wing updated
// cfg_     | in  | cfg_valid / cfg_ready (high)  | cfg_index, cfg_data
//
// a tick that does not update the wing goes from idle straight to the output state
// an updating tick walks the accelerometer history and then the three gain terms
// through the one shared multiplier, each followed by a drain, then shifts and limits
// s_tready is high only while idle; a result waits in place until m_tready
// asynchronous reset clears both histories, the tick phase and the held wing
module altitude_hold_autopilot_core #(
	parameter int HISTORY_DEPTH = 16,
	parameter int ACCEL_DEPTH   = 16,
	parameter int UPDATE_PERIOD = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// altitude_sample [7:0], accel_sample [16:8], valid_level [24:17]
	input  logic [ahap_pkg::TDATA_W-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// wing_command [8:0], altitude_locked [9], deviation [17:10], smoothed_altitude [25:18]
	output logic [ahap_pkg::TDATA_W-1:0]         m_tdata,
	// wing_updated [0]
	output logic [0:0]                           m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ahap_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ahap_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AIDX_W  = $clog2(ACCEL_DEPTH);
	localparam int WGT_SUM = ACCEL_DEPTH * (ACCEL_DEPTH + 1) / 2;
	localparam int WSUM_W  = ahap_pkg::ACC_IN_W + 1 + $clog2(WGT_SUM);
	localparam int INTEG_W = WSUM_W - ahap_pkg::INTEG_SHIFT;
	localparam int MB_W    = (INTEG_W > ahap_pkg::ERR_W) ? INTEG_W : ahap_pkg::ERR_W;
	localparam int PROD_W  = ahap_pkg::GAIN_W + 1 + MB_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int PH_W    = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;

	localparam logic [AIDX_W-1:0] AIDX_LAST = AIDX_W'(ACCEL_DEPTH - 1);
	localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(UPDATE_PERIOD - 1);
	localparam logic signed [ACC_W:0] LIM_HI = (ACC_W+1)'(ahap_pkg::WING_MAX);
	localparam logic signed [ACC_W:0] LIM_LO = (ACC_W+1)'(ahap_pkg::WING_MIN);
	localparam logic signed [ahap_pkg::ERR_W-1:0] DEV_HI = ahap_pkg::ERR_W'(ahap_pkg::DEV_MAX);
	localparam logic signed [ahap_pkg::ERR_W-1:0] DEV_LO = ahap_pkg::ERR_W'(ahap_pkg::DEV_MIN);

	// configuration
	logic [ahap_pkg::TGT_W-1:0]   target_q;
	ahap_pkg::mode_t              mode_q;
	logic [ahap_pkg::GAIN_W-1:0]  pgain_q;
	logic [ahap_pkg::GAIN_W-1:0]  vgain_q;
	logic [ahap_pkg::GAIN_W-1:0]  igain_q;
	logic [ahap_pkg::SCALE_W-1:0] scale_q;
	logic [ahap_pkg::GAIN_W-1:0]  mreset_q;

	// state
	logic [ahap_pkg::ALT_W-1:0]           alt_hist_q [HISTORY_DEPTH];
	logic signed [ahap_pkg::ACC_IN_W-1:0] accel_hist_q [ACCEL_DEPTH];
	logic [PH_W-1:0]                      phase_q;
	logic signed [ahap_pkg::WING_W-1:0]   held_q;
	ahap_pkg::state_t                     state_q, state_d;
	logic [AIDX_W-1:0]                    idx_q;

	// per tick payload
	logic signed [ahap_pkg::ERR_W-1:0]  err_q;
	logic signed [ahap_pkg::RATE_W-1:0] rate_q;
	logic signed [INTEG_W-1:0]          integ_q;
	logic signed [ACC_W-1:0]            acc_q;
	logic [ahap_pkg::ALT_W-1:0]         smooth_q;
	logic [ahap_pkg::DEV_W-1:0]         dev_q;
	logic                               locked_q;
	logic                               upd_q;

	// effective gains
	logic [ahap_pkg::GAIN_W-1:0] kp, kv, ki, mr;
	logic [ahap_pkg::KS_W-1:0]   ks;

	always_comb begin
		unique case (mode_q)
			ahap_pkg::MODE_STD: begin
				kp = ahap_pkg::GAIN_P_STD;
				kv = ahap_pkg::GAIN_V_STD;
				ki = ahap_pkg::GAIN_I_STD;
				ks = ahap_pkg::GAIN_S_STD;
				mr = ahap_pkg::GAIN_M_STD;
			end
			ahap_pkg::MODE_CUSTOM: begin
				kp = pgain_q;
				kv = vgain_q;
				ki = igain_q;
				ks = ahap_pkg::KS_W'(scale_q);
				mr = mreset_q;
			end
			ahap_pkg::MODE_ALT: begin
				kp = ahap_pkg::GAIN_P_ALT;
				kv = ahap_pkg::GAIN_V_STD;
				ki = ahap_pkg::GAIN_I_STD;
				ks = ahap_pkg::GAIN_S_STD;
				mr = ahap_pkg::GAIN_M_STD;
			end
			default: begin
				kp = '0;
				kv = '0;
				ki = '0;
				ks = '0;
				mr = mreset_q;
			end
		endcase
	end

	// input beat fields
	logic [ahap_pkg::ALT_W-1:0]           alt_in;
	logic signed [ahap_pkg::ACC_IN_W-1:0] accel_in;
	logic [ahap_pkg::LVL_W-1:0]           level_in;
	logic                                 accept;
	logic                                 is_update;

	assign alt_in    = s_tdata[7:0];
	assign accel_in  = s_tdata[16:8];
	assign level_in  = s_tdata[24:17];
	assign accept    = s_tvalid && s_tready;
	assign is_update = (phase_q == PH_LAST);

	// four sample average with the three newest stored averages
	logic [ahap_pkg::ALT_W+1:0]         avg_sum;
	logic [ahap_pkg::ALT_W-1:0]         avg;
	logic signed [ahap_pkg::ERR_W-1:0]  dev_raw;
	logic signed [ahap_pkg::ERR_W-1:0]  dev_clip;

	always_comb begin
		avg_sum = {2'b00, alt_in} + {2'b00, alt_hist_q[0]} + {2'b00, alt_hist_q[1]}
			+ {2'b00, alt_hist_q[2]};
		avg     = avg_sum[ahap_pkg::ALT_W+1:2];
		dev_raw = $signed({4'b0000, avg}) - $signed({2'b00, target_q});
		if (dev_raw > DEV_HI) begin
			dev_clip = DEV_HI;
		end else if (dev_raw < DEV_LO) begin
			dev_clip = DEV_LO;
		end else begin
			dev_clip = dev_raw;
		end
	end

	// shared multiplier
	logic                        mul_issue;
	logic [ahap_pkg::GAIN_W-1:0] mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]    prod;
	logic                        prod_valid;
	logic [ahap_pkg::GAIN_W-1:0] weight;

	assign weight = ahap_pkg::GAIN_W'(ACCEL_DEPTH) - ahap_pkg::GAIN_W'(idx_q);

	ahap_mul #(
		.A_W(ahap_pkg::GAIN_W),
		.B_W(MB_W)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (mul_issue),
		.a         (mul_a),
		.b         (mul_b),
		.prod      (prod),
		.prod_valid(prod_valid)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_issue = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ahap_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = is_update ? ahap_pkg::ST_WSUM : ahap_pkg::ST_OUT;
				end
			end
			ahap_pkg::ST_WSUM: begin
				mul_issue = 1'b1;
				mul_a     = weight;
				mul_b     = MB_W'(accel_hist_q[idx_q]);
				if (idx_q == AIDX_LAST) begin
					state_d = ahap_pkg::ST_WDRAIN;
				end
			end
			ahap_pkg::ST_WDRAIN: begin
				state_d = ahap_pkg::ST_TERMS;
			end
			ahap_pkg::ST_TERMS: begin
				mul_issue = 1'b1;
				case (idx_q[1:0])
					ahap_pkg::TERM_P: begin
						mul_a = kp;
						mul_b = MB_W'(err_q);
					end
					ahap_pkg::TERM_V: begin
						mul_a = kv;
						mul_b = MB_W'(rate_q);
					end
					default: begin
						mul_a = ki;
						mul_b = MB_W'(integ_q);
					end
				endcase
				if (idx_q[1:0] == ahap_pkg::TERM_I) begin
					state_d = ahap_pkg::ST_TDRAIN;
				end
			end
			ahap_pkg::ST_TDRAIN: begin
				state_d = ahap_pkg::ST_SHIFT;
			end
			ahap_pkg::ST_SHIFT: begin
				state_d = ahap_pkg::ST_LIMIT;
			end
			ahap_pkg::ST_LIMIT: begin
				state_d = ahap_pkg::ST_OUT;
			end
			ahap_pkg::ST_OUT: begin
				if (m_tready) begin
					state_d = ahap_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ahap_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			mode_q   <= ahap_pkg::MODE_STD;
			pgain_q  <= '0;
			vgain_q  <= '0;
			igain_q  <= '0;
			scale_q  <= ahap_pkg::SCALE_W'(1);
			mreset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ahap_pkg::REG_TARGET: target_q <= cfg_data[ahap_pkg::TGT_W-1:0];
				ahap_pkg::REG_MODE:   mode_q   <= ahap_pkg::mode_t'(cfg_data[1:0]);
				ahap_pkg::REG_PGAIN:  pgain_q  <= cfg_data[ahap_pkg::GAIN_W-1:0];
				ahap_pkg::REG_VGAIN:  vgain_q  <= cfg_data[ahap_pkg::GAIN_W-1:0];
				ahap_pkg::REG_IGAIN:  igain_q  <= cfg_data[ahap_pkg::GAIN_W-1:0];
				ahap_pkg::REG_SCALE:  scale_q  <= cfg_data[ahap_pkg::SCALE_W-1:0];
				ahap_pkg::REG_MRESET: mreset_q <= cfg_data[ahap_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// histories, phase, step counter and held wing
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] wsum_fin;
	logic signed [ACC_W-1:0] wsum_sh;
	logic signed [ACC_W:0]   lim_diff;
	logic signed [ACC_W:0]   lim_clip;

	always_comb begin
		prod_ext = ACC_W'(prod);
		wsum_fin = acc_q + prod_ext;
		wsum_sh  = wsum_fin >>> ahap_pkg::INTEG_SHIFT;
		lim_diff = (ACC_W+1)'(acc_q)
			- $signed({{(ACC_W+1-ahap_pkg::GAIN_W){1'b0}}, mr});
		if (lim_diff > LIM_HI) begin
			lim_clip = LIM_HI;
		end else if (lim_diff < LIM_LO) begin
			lim_clip = LIM_LO;
		end else begin
			lim_clip = lim_diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				alt_hist_q[i] <= '0;
			end
			for (int i = 0; i < ACCEL_DEPTH; i++) begin
				accel_hist_q[i] <= '0;
			end
			phase_q <= '0;
			held_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (accept) begin
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					alt_hist_q[i] <= alt_hist_q[i-1];
				end
				alt_hist_q[0] <= avg;
				for (int i = 1; i < ACCEL_DEPTH; i++) begin
					accel_hist_q[i] <= accel_hist_q[i-1];
				end
				accel_hist_q[0] <= accel_in;
				phase_q <= is_update ? '0 : phase_q + PH_W'(1);
				idx_q   <= '0;
			end
			if (state_q == ahap_pkg::ST_WSUM) begin
				idx_q <= (idx_q == AIDX_LAST) ? '0 : idx_q + AIDX_W'(1);
			end
			if (state_q == ahap_pkg::ST_TERMS) begin
				idx_q <= idx_q + AIDX_W'(1);
			end
			if (state_q == ahap_pkg::ST_LIMIT) begin
				held_q <= lim_clip[ahap_pkg::WING_W-1:0];
			end
		end
	end

	// per tick datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			smooth_q <= avg;
			err_q    <= $signed({2'b00, target_q}) - $signed({4'b0000, avg});
			// rate uses the entry that becomes the oldest after the push
			rate_q   <= $signed({2'b00, alt_hist_q[HISTORY_DEPTH-2]}) - $signed({2'b00, avg});
			// offset by half range flips the sign bit
			dev_q    <= {~dev_clip[ahap_pkg::DEV_W-1], dev_clip[ahap_pkg::DEV_W-2:0]};
			locked_q <= (level_in > ahap_pkg::LOCK_LEVEL);
			upd_q    <= is_update;
			acc_q    <= '0;
		end else if (state_q == ahap_pkg::ST_WDRAIN) begin
			integ_q <= wsum_sh[INTEG_W-1:0];
			acc_q   <= '0;
		end else if (state_q == ahap_pkg::ST_SHIFT) begin
			// shift counts past the width give sign fill
			acc_q <= acc_q >>> ks;
		end else if (prod_valid) begin
			acc_q <= wsum_fin;
		end
	end

	assign s_tready = (state_q == ahap_pkg::ST_IDLE);
	assign m_tvalid = (state_q == ahap_pkg::ST_OUT);
	assign m_tdata  = {6'b000000, smooth_q, dev_q, locked_q, held_q};
	assign m_tuser  = upd_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid))
	`ASSERT_IMPLY(a_mul_drained, state_q == ahap_pkg::ST_SHIFT, !prod_valid)
	`ASSERT_IMPLY(a_update_phase, m_tvalid && m_tuser[0], phase_q == '0)
	`ASSERT_IMPLY(a_wing_range, m_tvalid, held_q >= ahap_pkg::WING_W'(ahap_pkg::WING_MIN))

endmodule

### rtl/ahap_mul.sv
module ahap_mul #(
	parameter int A_W = 8,
	parameter int B_W = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     issue,
	input  logic [A_W-1:0]           a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W:0]  prod,
	output logic                     prod_valid
);

	logic signed [A_W+B_W:0] prod_q;
	logic                    valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= issue;
		end
	end

	// unsigned gain times signed operand
	always_ff @(posedge clk) begin
		if (issue) begin
			prod_q <= $signed({1'b0, a}) * b;
		end
	end

	assign prod       = prod_q;
	assign prod_valid = valid_q;

endmodule

### dv/altitude_hold_autopilot_core_tb.sv
`timescale 1ns / 100ps

module altitude_hold_autopilot_core_tb;
	import ahap_pkg::*;

	localparam int HIST_LEN         = 16;
	localparam int ACC_LEN          = 16;
	localparam int TICKS_PER_UPDATE = 4;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int RANDOM_PHASES    = 16;
	localparam int TICKS_PER_PHASE  = 95;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [WING_W-1:0] wing;
		logic                     updated;
		logic                     locked;
		logic [DEV_W-1:0]         dev;
		logic [ALT_W-1:0]         avg;
	} wing_result_t;

	typedef enum {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		logic [ALT_W-1:0]        alt;
		logic [ACC_IN_W-1:0]     acc;
		logic [LVL_W-1:0]        lvl;
		bit                      typed;
		wing_result_t            res;
	} stim_row_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} traffic_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// local copy of the block's registers and state
	logic [TGT_W-1:0]           tgt_reg = '0;
	mode_t                      mode_reg = MODE_STD;
	logic [GAIN_W-1:0]          kp_reg = '0;
	logic [GAIN_W-1:0]          kv_reg = '0;
	logic [GAIN_W-1:0]          ki_reg = '0;
	logic [SCALE_W-1:0]         ks_reg = 5'd1;
	logic [GAIN_W-1:0]          mr_reg = '0;
	logic [ALT_W-1:0]           alt_hist [HIST_LEN] = '{default: '0};
	logic signed [ACC_IN_W-1:0] accel_hist [ACC_LEN] = '{default: '0};
	int                         tick_count = 0;
	logic signed [WING_W-1:0]   held_wing = '0;

	wing_result_t wing_results_due [$];
	stim_row_t    directed_rows [$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           sender_gap_pct = 0;
	int           receiver_stall_pct = 0;
	int           hold_left = 0;

	altitude_hold_autopilot_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one sensor tick through the controller, updating the local state
	function automatic wing_result_t compute_tick(input logic [ALT_W-1:0] alt,
		input logic signed [ACC_IN_W-1:0] acc, input logic [LVL_W-1:0] lvl);
		wing_result_t r;
		longint kp, kv, ki, mr, total, accel_sum, wing;
		int unsigned ks;
		int avg, err, dev, i;
		case (mode_reg)
			MODE_STD: begin
				kp = GAIN_P_STD; kv = GAIN_V_STD; ki = GAIN_I_STD;
				ks = GAIN_S_STD; mr = GAIN_M_STD;
			end
			MODE_CUSTOM: begin
				kp = kp_reg; kv = kv_reg; ki = ki_reg;
				ks = ks_reg; mr = mr_reg;
			end
			MODE_ALT: begin
				kp = GAIN_P_ALT; kv = GAIN_V_STD; ki = GAIN_I_STD;
				ks = GAIN_S_STD; mr = GAIN_M_STD;
			end
			default: begin
				kp = 0; kv = 0; ki = 0; ks = 0; mr = mr_reg;
			end
		endcase

		for (i = HIST_LEN - 1; i > 0; i--)
			alt_hist[i] = alt_hist[i-1];
		for (i = ACC_LEN - 1; i > 0; i--)
			accel_hist[i] = accel_hist[i-1];
		alt_hist[0] = alt;
		accel_hist[0] = acc;

		avg = (int'(alt_hist[0]) + int'(alt_hist[1]) + int'(alt_hist[2])
			+ int'(alt_hist[3])) >> 2;
		alt_hist[0] = avg[ALT_W-1:0];

		err = int'(tgt_reg) - avg;
		total = kp * err;
		dev = -err;
		if (dev > DEV_MAX)
			dev = DEV_MAX;
		if (dev < DEV_MIN)
			dev = DEV_MIN;
		dev += 128;

		// height rate: oldest entry minus the average just stored
		total += kv * (int'(alt_hist[HIST_LEN-1]) - avg);

		r.updated = 1'b0;
		tick_count++;
		if (tick_count >= TICKS_PER_UPDATE) begin
			tick_count = 0;
			accel_sum = 0;
			for (i = 0; i < ACC_LEN; i++)
				accel_sum += longint'(ACC_LEN - i) * accel_hist[i];
			accel_sum = accel_sum >>> INTEG_SHIFT;
			total += ki * accel_sum;
			// shift count saturates, so the fixed sets leave only the sign
			wing = (total >>> ((ks > 63) ? 63 : ks)) - mr;
			if (wing < WING_MIN)
				wing = WING_MIN;
			if (wing > WING_MAX)
				wing = WING_MAX;
			held_wing = wing[WING_W-1:0];
			r.updated = 1'b1;
		end

		r.wing = held_wing;
		r.locked = (lvl > LOCK_LEVEL);
		r.dev = dev[DEV_W-1:0];
		r.avg = avg[ALT_W-1:0];
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.typed = 1'b0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_tick(input logic [ALT_W-1:0] alt,
		input logic [ACC_IN_W-1:0] acc, input logic [LVL_W-1:0] lvl);
		stim_row_t r;
		r.kind = ROW_TICK;
		r.alt = alt;
		r.acc = acc;
		r.lvl = lvl;
		r.typed = 1'b0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_checked(input logic [ALT_W-1:0] alt,
		input logic [ACC_IN_W-1:0] acc, input logic [LVL_W-1:0] lvl,
		input int wing, input bit upd, input bit lk, input int dev, input int avg);
		stim_row_t r;
		r.kind = ROW_TICK;
		r.alt = alt;
		r.acc = acc;
		r.lvl = lvl;
		r.typed = 1'b1;
		r.res.wing = wing[WING_W-1:0];
		r.res.updated = upd;
		r.res.locked = lk;
		r.res.dev = dev[DEV_W-1:0];
		r.res.avg = avg[ALT_W-1:0];
		directed_rows.push_back(r);
	endfunction

	// lower the input valid and wait until every due result has come back
	task automatic settle();
		s_tvalid = 1'b0;
		while (wing_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TARGET: tgt_reg = data[TGT_W-1:0];
			REG_MODE:   mode_reg = mode_t'(data[1:0]);
			REG_PGAIN:  kp_reg = data[GAIN_W-1:0];
			REG_VGAIN:  kv_reg = data[GAIN_W-1:0];
			REG_IGAIN:  ki_reg = data[GAIN_W-1:0];
			REG_SCALE:  ks_reg = data[SCALE_W-1:0];
			REG_MRESET: mr_reg = data[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic put_tick(input logic [ALT_W-1:0] alt, input logic [ACC_IN_W-1:0] acc,
		input logic [LVL_W-1:0] lvl, input bit typed = 1'b0,
		input wing_result_t typed_res = '0);
		wing_result_t model_res;
		cfg_valid = 1'b0;
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = TDATA_W'({lvl, acc, alt});
		do @(posedge clk); while (!s_tready);
		model_res = compute_tick(alt, acc, lvl);
		wing_results_due.push_back(typed ? typed_res : model_res);
		@(negedge clk);
	endtask

	// traffic settings change at the rising edge, away from the receiver's falling-edge drive
	task automatic set_traffic(input traffic_t kind, input int hold);
		cfg_valid = 1'b0;
		@(posedge clk);
		sender_gap_pct = (kind == IDLE_SEND) ? 68 : (kind == IDLE_BOTH) ? 27 : 0;
		receiver_stall_pct = (kind == IDLE_RECV) ? 68 : (kind == IDLE_BOTH) ? 27 : 0;
		hold_left = hold;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else
			m_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin : result_check
		wing_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.wing = m_tdata[WING_W-1:0];
			got.locked = m_tdata[WING_W];
			got.dev = m_tdata[WING_W+1 +: DEV_W];
			got.avg = m_tdata[WING_W+1+DEV_W +: ALT_W];
			got.updated = m_tuser[0];
			if (wing_results_due.size() == 0)
				note_failure($sformatf("result beat with nothing due: wing %0d upd %0b",
					got.wing, got.updated));
			else begin
				want = wing_results_due.pop_front();
				if (got !== want)
					note_failure($sformatf({"result mismatch: wing %0d/%0d upd %0b/%0b ",
						"lock %0b/%0b dev %0d/%0d avg %0d/%0d (expected/actual)"},
						want.wing, got.wing, want.updated, got.updated,
						want.locked, got.locked, want.dev, got.dev, want.avg, got.avg));
			end
		end
	end

	// counts cycles in which no beat moves on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int ph, n, tgt, kp, kv, ki, sh, mr, stride, alt_walk, acc_walk;
		mode_t mode;
		logic [ALT_W-1:0] alt;
		logic [ACC_IN_W-1:0] acc;
		logic [LVL_W-1:0] lvl;

		// after reset with fixed gains and an all-zero history the fourth tick
		// lands on minus the fixed offset; the lock flag flips between 127 and 128
		add_checked(8'd0, 9'h000, 8'd0, 0, 1'b0, 1'b0, 128, 0);
		add_checked(8'd0, 9'h000, 8'd127, 0, 1'b0, 1'b0, 128, 0);
		add_checked(8'd0, 9'h000, 8'd128, 0, 1'b0, 1'b1, 128, 0);
		add_checked(8'd0, 9'h000, 8'd255, -102, 1'b1, 1'b1, 128, 0);
		// full altitude, accelerometer at both ends and one above the low end
		add_tick(8'd255, 9'h0ff, 8'd1);
		add_tick(8'd255, 9'h101, 8'd254);
		add_tick(8'd255, 9'h100, 8'd128);
		add_tick(8'd255, 9'h0ff, 8'd127);
		// custom gains at full scale, target past the range, no shift: high limit
		add_cfg(REG_TARGET, 10'd1023);
		add_cfg(REG_MODE, MODE_CUSTOM);
		add_cfg(REG_PGAIN, 10'd255);
		add_cfg(REG_VGAIN, 10'd255);
		add_cfg(REG_IGAIN, 10'd255);
		add_cfg(REG_SCALE, 10'd0);
		add_cfg(REG_MRESET, 10'd0);
		add_cfg(REG_UNUSED, 10'h3ff);
		add_tick(8'd0, 9'h100, 8'd200);
		add_tick(8'd0, 9'h101, 8'd50);
		add_tick(8'd128, 9'h0ff, 8'd128);
		add_tick(8'd0, 9'h100, 8'd0);
		// target zero with a high history: low limit
		add_cfg(REG_TARGET, 10'd0);
		add_tick(8'd255, 9'h0ff, 8'd90);
		add_tick(8'd255, 9'h0ff, 8'd255);
		add_tick(8'd255, 9'h000, 8'd128);
		add_tick(8'd255, 9'h1ff, 8'd127);
		// alternate fixed gains
		add_cfg(REG_MODE, MODE_ALT);
		add_tick(8'd255, 9'h001, 8'd0);
		add_tick(8'd0, 9'h101, 8'd255);
		add_tick(8'd255, 9'h0ff, 8'd128);
		add_tick(8'd1, 9'h100, 8'd64);
		// manual: only the offset is left
		add_cfg(REG_MRESET, 10'd255);
		add_cfg(REG_MODE, MODE_MANUAL);
		add_tick(8'd77, 9'h080, 8'd127);
		add_tick(8'd200, 9'h180, 8'd128);
		add_tick(8'd3, 9'h0aa, 8'd33);
		add_tick(8'd170, 9'h155, 8'd204);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_CFG)
				write_reg(directed_rows[n].idx, directed_rows[n].data);
			else
				put_tick(directed_rows[n].alt, directed_rows[n].acc, directed_rows[n].lvl,
					directed_rows[n].typed, directed_rows[n].res);
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			kp = $urandom_range(0, 255);
			kv = $urandom_range(0, 255);
			ki = $urandom_range(0, 255);
			mr = $urandom_range(0, 255);
			if ($urandom_range(0, 3) == 0)
				tgt = $urandom_range(0, 1023);
			else
				tgt = $urandom_range(0, 260);
			if ($urandom_range(0, 3) == 0)
				sh = $urandom_range(0, 31);
			else
				sh = $urandom_range(4, 12);
			case (ph)
				0: begin
					tgt = 0; kp = 0; kv = 0; ki = 0; sh = 1; mr = 0;
				end
				1: begin
					tgt = 1023; kp = 255; kv = 255; ki = 255; sh = 16; mr = 255;
				end
				2: sh = 31;
				3: sh = 0;
				default: ;
			endcase
			mode = (ph < 4) ? MODE_CUSTOM : mode_t'(ph % 4);

			write_reg(REG_TARGET, tgt[TGT_W-1:0]);
			write_reg(REG_MODE, {8'($urandom), mode});
			write_reg(REG_PGAIN, {2'($urandom), kp[GAIN_W-1:0]});
			write_reg(REG_VGAIN, {2'($urandom), kv[GAIN_W-1:0]});
			write_reg(REG_IGAIN, {2'($urandom), ki[GAIN_W-1:0]});
			write_reg(REG_SCALE, {5'($urandom), sh[SCALE_W-1:0]});
			write_reg(REG_MRESET, {2'($urandom), mr[GAIN_W-1:0]});
			if (ph % 2 == 0)
				write_reg(REG_UNUSED, 10'($urandom));

			// one phase keeps the result side blocked long enough to back up the input
			set_traffic(traffic_t'(ph % 4), (ph == 5) ? HOLD_OFF_CYCLES : 0);

			alt_walk = (tgt <= 255) ? tgt : $urandom_range(0, 255);
			acc_walk = 0;
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				// mostly a slow drift around the target, now and then a wild sample
				if ($urandom_range(0, 3) != 0) begin
					stride = $urandom_range(0, 12);
					alt_walk += stride - 6;
					if (alt_walk < 0)
						alt_walk = 0;
					if (alt_walk > 255)
						alt_walk = 255;
					stride = $urandom_range(0, 80);
					acc_walk += stride - 40;
					if (acc_walk < -256)
						acc_walk = -256;
					if (acc_walk > 255)
						acc_walk = 255;
					alt = alt_walk[ALT_W-1:0];
					acc = acc_walk[ACC_IN_W-1:0];
				end else begin
					alt = 8'($urandom);
					acc = 9'($urandom);
				end
				if ($urandom_range(0, 3) == 0)
					lvl = $urandom_range(120, 135);
				else
					lvl = 8'($urandom);
				put_tick(alt, acc, lvl);
			end
		end

		settle();
		repeat (ACC_LEN + 8) @(negedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
